// ----- rtl/ssob_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssob_pkg
// shared widths, stage counts and pipeline types of the 2x2 barrier core
// ----------------------------------------------------------------------------
package ssob_pkg;

   // input format and lanes
   localparam int IN_W      = 16;
   localparam int FRAC_BITS = 12;
   localparam int LANES     = 4;
   localparam int L00       = 0;
   localparam int L01       = 1;
   localparam int L10       = 2;
   localparam int L11       = 3;

   // results
   localparam int Q_W = 32;

   // min_det register
   localparam int                   MIN_DET_W     = 31;
   localparam logic [MIN_DET_W-1:0] MIN_DET_RESET = MIN_DET_W'(1);

   // internal widths
   localparam int TAU_W  = 2 * IN_W;
   localparam int TAU2_W = 2 * TAU_W;
   localparam int TAU3_W = 3 * TAU_W - 2;
   localparam int SQ_W   = 2 * IN_W;
   localparam int SQS_W  = SQ_W + 1;
   localparam int TR_W   = IN_W + 1;
   localparam int CF_W   = IN_W + 1;
   localparam int E_W    = TAU_W + 2;
   localparam int NUM_W  = TAU2_W + 2;
   localparam int TT_W   = TR_W + TAU_W + 1;
   localparam int TI_W   = IN_W + TAU_W + 1;
   localparam int K_W    = TT_W;
   localparam int P_W    = TAU2_W + 2;
   localparam int PM_W   = TAU2_W;
   localparam int DIV_W  = TAU3_W;

   // output scaling
   localparam int M_SHIFT = 16;
   localparam int M_DROP  = Q_W - M_SHIFT;
   localparam int G_SHIFT = 2 * FRAC_BITS + 17;
   localparam int G_PRE   = G_SHIFT - Q_W;

   // pipeline depth
   localparam int FRONT_STAGES = 8;
   localparam int PIPE_STAGES  = FRONT_STAGES + Q_W + 1;

   typedef struct packed {
      logic             vres;
      logic             sat_m;
      logic [LANES-1:0] sat_g;
      logic [LANES-1:0] neg;
   } side_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] dvs;
      logic [Q_W-1:0]   lo;
   } div_in_type;

endpackage

// ----- rtl/ssob_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssob_front
// eight-stage arithmetic front end: determinant, products, dividends, divisors
// ----------------------------------------------------------------------------
module ssob_front (
   input  logic                                  clock,
   input  logic [ssob_pkg::FRONT_STAGES-1:0]     en,
   input  logic [ssob_pkg::MIN_DET_W-1:0]        min_det,
   input  logic signed [ssob_pkg::IN_W-1:0]      t_00,
   input  logic signed [ssob_pkg::IN_W-1:0]      t_01,
   input  logic signed [ssob_pkg::IN_W-1:0]      t_10,
   input  logic signed [ssob_pkg::IN_W-1:0]      t_11,
   output ssob_pkg::side_type                    side,
   output ssob_pkg::div_in_type                  m_div,
   output ssob_pkg::div_in_type [ssob_pkg::LANES-1:0] g_div
);
   import ssob_pkg::*;

   // stage 1
   logic signed [IN_W-1:0]  t_in [LANES];
   logic signed [IN_W-1:0]  t_s1_ff [LANES];
   logic signed [SQ_W-1:0]  ad_s1_in, bc_s1_in, ad_s1_ff, bc_s1_ff;
   logic signed [SQ_W-1:0]  sq_s1_in [LANES];
   logic signed [SQ_W-1:0]  sq_s1_ff [LANES];
   logic signed [TR_W-1:0]  tr_s1_in, tr_s1_ff;

   // stage 2
   logic signed [IN_W-1:0]  t_s2_ff [LANES];
   logic signed [TR_W-1:0]  tr_s2_ff;
   logic signed [TAU_W:0]   det_s2_in, det_s2_ff;
   logic [SQS_W-1:0]        sqs_s2_in, sqs_s2_ff;
   logic [SQ_W-1:0]         off_s2_in, off_s2_ff;

   // stage 3
   logic                    vres_s3_in, vres_s3_ff;
   logic signed [TAU_W:0]   det_s;
   logic [TAU_W-1:0]        det_s3_ff;
   logic [TAU2_W-1:0]       dsq_s3_in, dsq_s3_ff;
   logic signed [E_W-1:0]   e_s3_in [2];
   logic signed [E_W-1:0]   e_s3_ff [2];
   logic signed [TT_W-1:0]  trd_s3_in, trd_s3_ff;
   logic signed [TI_W-1:0]  td_s3_in [LANES];
   logic signed [TI_W-1:0]  td_s3_ff [LANES];
   logic [SQS_W-1:0]        sqs_s3_ff;
   logic [SQ_W-1:0]         off_s3_ff;
   logic signed [IN_W-1:0]  t_s3_ff [LANES];

   // stage 4
   logic                    vres_s4_ff;
   logic [TAU2_W-1:0]       dsq_s4_ff;
   logic signed [2*E_W-1:0] esq_p [2];
   logic [NUM_W-1:0]        esq_s4_ff [2];
   logic signed [K_W-1:0]   k_s4_in, k_s4_ff;
   logic signed [P_W-1:0]   dsq_p;
   logic signed [P_W-1:0]   base_s4_in [LANES];
   logic signed [P_W-1:0]   base_s4_ff [LANES];
   logic [TAU2_W-1:0]       tph_s4_in, tpl_s4_in, tph_s4_ff, tpl_s4_ff;
   logic [SQ_W-1:0]         off_s4_ff;
   logic signed [IN_W-1:0]  t_s4_ff [LANES];

   // stage 5
   logic                    vres_s5_ff;
   logic [TAU2_W-1:0]       dsq_s5_ff;
   logic [NUM_W-1:0]        num_s5_in, num_s5_ff;
   logic signed [CF_W-1:0]  cof [LANES];
   logic signed [P_W-1:0]   kc_s5_in [LANES];
   logic signed [P_W-1:0]   kc_s5_ff [LANES];
   logic signed [P_W-1:0]   base_s5_ff [LANES];
   logic [TAU3_W-1:0]       tcube_s5_in, tcube_s5_ff;

   // stage 6
   logic                    vres_s6_ff;
   logic [DIV_W-1:0]        mrem_s6_in, mrem_s6_ff;
   logic [DIV_W-1:0]        mdvs_s6_ff;
   logic [Q_W-1:0]          mlo_s6_ff;
   logic                    satm_s6_ff;
   logic signed [P_W-1:0]   p_s6_ff [LANES];
   logic [TAU3_W-1:0]       tcube_s6_ff;

   // stage 7
   logic                    vres_s7_ff, satm_s7_ff;
   logic [DIV_W-1:0]        mrem_s7_ff, mdvs_s7_ff;
   logic [Q_W-1:0]          mlo_s7_ff;
   logic [LANES-1:0]        neg_s7_ff;
   logic signed [P_W-1:0]   pabs [LANES];
   logic [PM_W-1:0]         pm_s7_ff [LANES];
   logic [TAU3_W-1:0]       tcube_s7_ff;

   // stage 8
   side_type                side_in, side_ff;
   div_in_type              mdiv_ff;
   div_in_type [LANES-1:0]  gdiv_in, gdiv_ff;

   assign t_in[L00] = t_00;
   assign t_in[L01] = t_01;
   assign t_in[L10] = t_10;
   assign t_in[L11] = t_11;

   // stage 1: cross products, squares, trace
   always_comb begin
      ad_s1_in = t_00 * t_11;
      bc_s1_in = t_01 * t_10;
      tr_s1_in = TR_W'(t_00) + TR_W'(t_11);
      for (int i = 0; i < LANES; i++) begin
         sq_s1_in[i] = t_in[i] * t_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_s1_ff  <= t_in;
         ad_s1_ff <= ad_s1_in;
         bc_s1_ff <= bc_s1_in;
         sq_s1_ff <= sq_s1_in;
         tr_s1_ff <= tr_s1_in;
      end
   end

   // stage 2: determinant and squared norm
   always_comb begin
      det_s2_in = (TAU_W+1)'(ad_s1_ff) - (TAU_W+1)'(bc_s1_ff);
      sqs_s2_in = SQS_W'($unsigned(sq_s1_ff[L00])) + SQS_W'($unsigned(sq_s1_ff[L01]))
                + SQS_W'($unsigned(sq_s1_ff[L10])) + SQS_W'($unsigned(sq_s1_ff[L11]));
      off_s2_in = $unsigned(sq_s1_ff[L01]) + $unsigned(sq_s1_ff[L10]);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t_s2_ff   <= t_s1_ff;
         tr_s2_ff  <= tr_s1_ff;
         det_s2_ff <= det_s2_in;
         sqs_s2_ff <= sqs_s2_in;
         off_s2_ff <= off_s2_in;
      end
   end

   // stage 3: acceptance, det products
   always_comb begin
      det_s      = $signed({1'b0, det_s2_ff[TAU_W-1:0]});
      vres_s3_in = !det_s2_ff[TAU_W] && (det_s2_ff != '0)
                   && (det_s2_ff[TAU_W-1:0] >= TAU_W'(min_det));
      dsq_s3_in  = det_s2_ff[TAU_W-1:0] * det_s2_ff[TAU_W-1:0];
      e_s3_in[0] = (E_W'(t_s2_ff[L11]) <<< FRAC_BITS) - E_W'(det_s);
      e_s3_in[1] = (E_W'(t_s2_ff[L00]) <<< FRAC_BITS) - E_W'(det_s);
      trd_s3_in  = TT_W'(tr_s2_ff) * TT_W'(det_s);
      for (int i = 0; i < LANES; i++) begin
         td_s3_in[i] = TI_W'(t_s2_ff[i]) * TI_W'(det_s);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         vres_s3_ff <= vres_s3_in;
         det_s3_ff  <= det_s2_ff[TAU_W-1:0];
         dsq_s3_ff  <= dsq_s3_in;
         e_s3_ff    <= e_s3_in;
         trd_s3_ff  <= trd_s3_in;
         td_s3_ff   <= td_s3_in;
         sqs_s3_ff  <= sqs_s2_ff;
         off_s3_ff  <= off_s2_ff;
         t_s3_ff    <= t_s2_ff;
      end
   end

   // stage 4: diagonal error squares, k, gradient base, det cube partials
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         esq_p[i] = e_s3_ff[i] * e_s3_ff[i];
      end
      k_s4_in = trd_s3_ff - (K_W'($signed({1'b0, sqs_s3_ff})) <<< FRAC_BITS);
      dsq_p   = $signed(P_W'(dsq_s3_ff));
      for (int i = 0; i < LANES; i++) begin
         base_s4_in[i] = P_W'(td_s3_ff[i]) <<< FRAC_BITS;
         if (i == L00 || i == L11) begin
            base_s4_in[i] = (P_W'(td_s3_ff[i]) <<< FRAC_BITS) - dsq_p;
         end
      end
      tph_s4_in = dsq_s3_ff[TAU2_W-1:TAU_W] * det_s3_ff;
      tpl_s4_in = dsq_s3_ff[TAU_W-1:0] * det_s3_ff;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         vres_s4_ff   <= vres_s3_ff;
         dsq_s4_ff    <= dsq_s3_ff;
         esq_s4_ff[0] <= NUM_W'($unsigned(esq_p[0]));
         esq_s4_ff[1] <= NUM_W'($unsigned(esq_p[1]));
         k_s4_ff      <= k_s4_in;
         base_s4_ff   <= base_s4_in;
         tph_s4_ff    <= tph_s4_in;
         tpl_s4_ff    <= tpl_s4_in;
         off_s4_ff    <= off_s3_ff;
         t_s4_ff      <= t_s3_ff;
      end
   end

   // stage 5: metric numerator, k times cofactor, det cube
   always_comb begin
      num_s5_in = esq_s4_ff[0] + esq_s4_ff[1] + (NUM_W'(off_s4_ff) << (2 * FRAC_BITS));
      cof[L00]  = CF_W'(t_s4_ff[L11]);
      cof[L01]  = -CF_W'(t_s4_ff[L10]);
      cof[L10]  = -CF_W'(t_s4_ff[L01]);
      cof[L11]  = CF_W'(t_s4_ff[L00]);
      for (int i = 0; i < LANES; i++) begin
         kc_s5_in[i] = P_W'(k_s4_ff) * P_W'(cof[i]);
      end
      tcube_s5_in = TAU3_W'({tph_s4_ff, {TAU_W{1'b0}}}) + TAU3_W'(tpl_s4_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         vres_s5_ff  <= vres_s4_ff;
         dsq_s5_ff   <= dsq_s4_ff;
         num_s5_ff   <= num_s5_in;
         kc_s5_ff    <= kc_s5_in;
         base_s5_ff  <= base_s4_ff;
         tcube_s5_ff <= tcube_s5_in;
      end
   end

   // stage 6: gradient numerators, metric overflow check
   assign mrem_s6_in = DIV_W'(num_s5_ff >> M_DROP);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         vres_s6_ff  <= vres_s5_ff;
         mrem_s6_ff  <= mrem_s6_in;
         mdvs_s6_ff  <= DIV_W'(dsq_s5_ff);
         mlo_s6_ff   <= Q_W'(num_s5_ff << M_SHIFT);
         satm_s6_ff  <= mrem_s6_in >= DIV_W'(dsq_s5_ff);
         tcube_s6_ff <= tcube_s5_ff;
         for (int i = 0; i < LANES; i++) begin
            p_s6_ff[i] <= base_s5_ff[i] + kc_s5_ff[i];
         end
      end
   end

   // stage 7: sign and magnitude of gradient numerators
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         pabs[i] = p_s6_ff[i][P_W-1] ? -p_s6_ff[i] : p_s6_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         vres_s7_ff  <= vres_s6_ff;
         satm_s7_ff  <= satm_s6_ff;
         mrem_s7_ff  <= mrem_s6_ff;
         mdvs_s7_ff  <= mdvs_s6_ff;
         mlo_s7_ff   <= mlo_s6_ff;
         tcube_s7_ff <= tcube_s6_ff;
         for (int i = 0; i < LANES; i++) begin
            neg_s7_ff[i] <= p_s6_ff[i][P_W-1];
            pm_s7_ff[i]  <= PM_W'($unsigned(pabs[i]));
         end
      end
   end

   // stage 8: gradient dividends and overflow checks
   always_comb begin
      side_in.vres  = vres_s7_ff;
      side_in.sat_m = satm_s7_ff;
      side_in.neg   = neg_s7_ff;
      for (int i = 0; i < LANES; i++) begin
         gdiv_in[i].rem   = DIV_W'(pm_s7_ff[i]) << G_PRE;
         gdiv_in[i].dvs   = DIV_W'(tcube_s7_ff);
         gdiv_in[i].lo    = '0;
         side_in.sat_g[i] = gdiv_in[i].rem >= gdiv_in[i].dvs;
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         side_ff       <= side_in;
         mdiv_ff.rem   <= mrem_s7_ff;
         mdiv_ff.dvs   <= mdvs_s7_ff;
         mdiv_ff.lo    <= mlo_s7_ff;
         gdiv_ff       <= gdiv_in;
      end
   end

   assign side  = side_ff;
   assign m_div = mdiv_ff;
   assign g_div = gdiv_ff;

endmodule

// ----- rtl/ssob_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssob_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ssob_div (
   input  logic                       clock,
   input  logic [ssob_pkg::Q_W-1:0]   en,
   input  ssob_pkg::div_in_type       din,
   output logic [ssob_pkg::Q_W-1:0]   quo
);
   import ssob_pkg::*;

   logic [DIV_W-1:0] rem_ff [Q_W-1];
   logic [DIV_W-1:0] dvs_ff [Q_W-1];
   logic [Q_W-1:0]   lo_ff  [Q_W-1];
   logic [Q_W-1:0]   q_ff   [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_step
      logic [DIV_W-1:0] rem_prev, dvs_prev;
      logic [Q_W-1:0]   lo_prev, q_prev;
      logic [DIV_W:0]   trial, diff;
      logic             take;
      logic [Q_W-1:0]   q_in;

      if (j == 0) begin : g_first
         assign rem_prev = din.rem;
         assign dvs_prev = din.dvs;
         assign lo_prev  = din.lo;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign dvs_prev = dvs_ff[j-1];
         assign lo_prev  = lo_ff[j-1];
         assign q_prev   = q_ff[j-1];
      end

      // remainder stays below divisor, so the borrow bit decides the step
      assign trial = {rem_prev, lo_prev[Q_W-1]};
      assign diff  = trial - {1'b0, dvs_prev};
      assign take  = !diff[DIV_W];
      assign q_in  = {q_prev[Q_W-2:0], take};

      always_ff @(posedge clock) begin
         if (en[j]) begin
            q_ff[j] <= q_in;
         end
      end

      if (j < Q_W - 1) begin : g_carry
         logic [DIV_W-1:0] rem_in;
         logic [Q_W-1:0]   lo_in;

         assign rem_in = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         assign lo_in  = {lo_prev[Q_W-2:0], 1'b0};

         always_ff @(posedge clock) begin
            if (en[j]) begin
               rem_ff[j] <= rem_in;
               dvs_ff[j] <= dvs_prev;
               lo_ff[j]  <= lo_in;
            end
         end
      end
   end

   assign quo = q_ff[Q_W-1];

endmodule

// ----- rtl/shape_size_orient_barrier_2x2_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_size_orient_barrier_2x2_core
// barrier metric and gradient of a 2x2 matrix, fully pipelined
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_valid/req_ready   | t_00 t_01 t_10 t_11, signed q4.12
//  rsp     | out | rsp_valid/rsp_ready   | valid_res, metric u16.16, grad s16.16
//  csr     | in  | csr_valid/csr_ready   | min_det, q8.24
//
//  one request enters per cycle unless a full pipe stalls on rsp; 8 arithmetic
//  stages, 32 divider stages (one quotient bit each) and the output register
//  each hold a valid bit; a stage loads when it or a later stage has a gap or
//  rsp drains, so bubbles close up and a stalled rsp holds only what is full
//  synchronous active-high reset clears the valid bits and loads min_det = 1
//  csr_ready is always high; min_det is sampled at stage 3
// ----------------------------------------------------------------------------
module shape_size_orient_barrier_2x2_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [ssob_pkg::IN_W-1:0]   req_t_00,
   input  logic signed [ssob_pkg::IN_W-1:0]   req_t_01,
   input  logic signed [ssob_pkg::IN_W-1:0]   req_t_10,
   input  logic signed [ssob_pkg::IN_W-1:0]   req_t_11,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_valid_res,
   output logic [ssob_pkg::Q_W-1:0]           rsp_metric,
   output logic signed [ssob_pkg::Q_W-1:0]    rsp_grad_00,
   output logic signed [ssob_pkg::Q_W-1:0]    rsp_grad_01,
   output logic signed [ssob_pkg::Q_W-1:0]    rsp_grad_10,
   output logic signed [ssob_pkg::Q_W-1:0]    rsp_grad_11,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ssob_pkg::MIN_DET_W-1:0]     csr_min_det
);
   import ssob_pkg::*;

   localparam int LAST = PIPE_STAGES - 1;

   // per-stage valid bits and advance enables
   logic [PIPE_STAGES-1:0] v_ff, v_in, en;

   // min_det register
   logic [MIN_DET_W-1:0] min_det_ff;

   // front end to dividers
   side_type               front_side;
   div_in_type             m_div;
   div_in_type [LANES-1:0] g_div;

   // divider results and the flags that travel beside them
   logic [Q_W-1:0] q_m;
   logic [Q_W-1:0] q_g [LANES];
   side_type       side_ff [Q_W];

   // output register
   logic           vres_in, vres_ff;
   logic [Q_W-1:0] metric_in, metric_ff;
   logic [Q_W-1:0] grad_in [LANES];
   logic [Q_W-1:0] grad_ff [LANES];

   // a stage may load when it or any stage after it has a gap, or rsp drains
   for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_en
      assign en[k] = rsp_ready || !(&v_ff[LAST:k]);
   end

   assign v_in = (v_ff & ~en) | ({v_ff[LAST-1:0], req_valid} & en);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = en[0];

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_det_ff <= MIN_DET_RESET;
      end else if (csr_valid && csr_ready) begin
         min_det_ff <= csr_min_det;
      end
   end

   // arithmetic front end
   ssob_front u_front (
      .clock   (clock),
      .en      (en[FRONT_STAGES-1:0]),
      .min_det (min_det_ff),
      .t_00    (req_t_00),
      .t_01    (req_t_01),
      .t_10    (req_t_10),
      .t_11    (req_t_11),
      .side    (front_side),
      .m_div   (m_div),
      .g_div   (g_div)
   );

   // metric: num * 2^16 / det^2
   ssob_div u_div_m (
      .clock (clock),
      .en    (en[FRONT_STAGES +: Q_W]),
      .din   (m_div),
      .quo   (q_m)
   );

   // gradient: |p| * 2^(2f+17) / det^3, one divider per entry
   for (genvar i = 0; i < LANES; i++) begin : g_div_g
      ssob_div u_div_g (
         .clock (clock),
         .en    (en[FRONT_STAGES +: Q_W]),
         .din   (g_div[i]),
         .quo   (q_g[i])
      );
   end

   // flags ride alongside the divider stages
   for (genvar j = 0; j < Q_W; j++) begin : g_side
      if (j == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en[FRONT_STAGES]) begin
               side_ff[j] <= front_side;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (en[FRONT_STAGES + j]) begin
               side_ff[j] <= side_ff[j-1];
            end
         end
      end
   end

   // signed saturation of one gradient entry, zero when rejected
   function automatic logic [Q_W-1:0] grad_final(input logic vres, input logic sat,
                                                 input logic neg, input logic [Q_W-1:0] q);
      logic [Q_W-1:0] limit;
      logic [Q_W-1:0] m;
      limit = neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      m     = (sat || (q > limit)) ? limit : q;
      return vres ? (neg ? -m : m) : '0;
   endfunction

   // output stage: saturation, sign and rejection
   always_comb begin
      vres_in   = side_ff[Q_W-1].vres;
      metric_in = !vres_in ? '0 : (side_ff[Q_W-1].sat_m ? '1 : q_m);
      for (int i = 0; i < LANES; i++) begin
         grad_in[i] = grad_final(vres_in, side_ff[Q_W-1].sat_g[i],
                                 side_ff[Q_W-1].neg[i], q_g[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         vres_ff   <= vres_in;
         metric_ff <= metric_in;
         grad_ff   <= grad_in;
      end
   end

   assign rsp_valid     = v_ff[LAST];
   assign rsp_valid_res = vres_ff;
   assign rsp_metric    = metric_ff;
   assign rsp_grad_00   = $signed(grad_ff[L00]);
   assign rsp_grad_01   = $signed(grad_ff[L01]);
   assign rsp_grad_10   = $signed(grad_ff[L10]);
   assign rsp_grad_11   = $signed(grad_ff[L11]);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // an accepted request always lands in the first stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[0])
      else $error("accepted request lost at stage 1");

   // a full pipe with a stalled rsp takes nothing more
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&v_ff) && !rsp_ready |-> !req_ready)
      else $error("request taken while pipe is full and stalled");

   // a rejected matrix gives zero outputs
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> (rsp_metric == '0) && (rsp_grad_00 == '0)
         && (rsp_grad_01 == '0) && (rsp_grad_10 == '0) && (rsp_grad_11 == '0))
      else $error("rejected matrix with nonzero outputs");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barrier core testbench
// drives 2x2 matrices through the pipelined barrier core under several
// min_det settings and flow-control patterns; every response is checked
// against an exact integer prediction of metric and gradient
// ----------------------------------------------------------------------------

class barrier_scoreboard;
   typedef struct {
      logic        vres;
      logic [31:0] metric;
      logic [31:0] grad [4];
   } barrier_result_type;

   barrier_result_type pending [$];
   logic [30:0]        min_det;
   int                 errors;
   int                 n_checked;
   int                 n_valid;

   function new();
      min_det   = 31'd1;
      errors    = 0;
      n_checked = 0;
      n_valid   = 0;
   endfunction

   // exact barrier metric and gradient of one matrix
   function void note_request(logic signed [15:0] a, logic signed [15:0] b,
                              logic signed [15:0] c, logic signed [15:0] d);
      barrier_result_type r;
      logic signed [63:0] t [4];
      logic signed [63:0] cf [4];
      logic signed [63:0] e [4];
      logic signed [63:0] tau, tau2, tr, sq, k;
      logic signed [127:0] num, p, base;
      logic [127:0]        q, pm;
      logic [31:0]         lim;
      logic                neg;
      r.vres = 1'b0;
      r.metric = '0;
      for (int i = 0; i < 4; i++) r.grad[i] = '0;
      t[0] = a; t[1] = b; t[2] = c; t[3] = d;
      tau = t[0] * t[3] - t[1] * t[2];
      if (tau > 0 && tau >= $signed({33'd0, min_det})) begin
         r.vres = 1'b1;
         tau2 = tau * tau;
         tr = t[0] + t[3];
         sq = t[0] * t[0] + t[1] * t[1] + t[2] * t[2] + t[3] * t[3];
         e[0] = t[3] * 4096 - tau;
         e[1] = -t[1] * 4096;
         e[2] = -t[2] * 4096;
         e[3] = t[0] * 4096 - tau;
         num = 0;
         for (int i = 0; i < 4; i++) num += 128'(e[i]) * 128'(e[i]);
         q = (128'(num) << 16) / 128'(tau2);
         r.metric = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
         cf[0] = t[3]; cf[1] = -t[2]; cf[2] = -t[1]; cf[3] = t[0];
         k = tr * tau - sq * 4096;
         for (int i = 0; i < 4; i++) begin
            base = 128'(t[i] * tau * 4096) - ((i == 0 || i == 3) ? 128'(tau2) : 128'sd0);
            p = base + 128'(k) * 128'(cf[i]);
            neg = p < 0;
            pm = neg ? -p : p;
            q = ((pm << 41) / 128'(tau2)) / 128'(tau);
            lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.grad[i] = (q > 128'(lim)) ? lim : q[31:0];
            if (neg) r.grad[i] = -r.grad[i];
         end
      end
      pending.push_back(r);
   endfunction

   function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   function void check_response(logic vres, logic [31:0] metric, logic [31:0] g00,
                                logic [31:0] g01, logic [31:0] g10, logic [31:0] g11);
      barrier_result_type r;
      if (pending.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      r = pending.pop_front();
      n_checked++;
      if (r.vres) n_valid++;
      check_field("valid_res", 32'(r.vres), 32'(vres));
      check_field("metric", r.metric, metric);
      check_field("grad_00", r.grad[0], g00);
      check_field("grad_01", r.grad[1], g01);
      check_field("grad_10", r.grad[2], g10);
      check_field("grad_11", r.grad[3], g11);
   endfunction
endclass

module tb;
   import ssob_pkg::*;

   localparam int LATENCY   = 41;
   localparam int STALL_MAX = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [IN_W-1:0] req_t_00 = '0, req_t_01 = '0, req_t_10 = '0, req_t_11 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_valid_res;
   logic [Q_W-1:0] rsp_metric;
   logic signed [Q_W-1:0] rsp_grad_00, rsp_grad_01, rsp_grad_10, rsp_grad_11;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [MIN_DET_W-1:0] csr_min_det = '0;

   barrier_scoreboard sb = new();

   // idling odds in percent for the current phase
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   int n_requests = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   shape_size_orient_barrier_2x2_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_t_00(req_t_00), .req_t_01(req_t_01),
      .req_t_10(req_t_10), .req_t_11(req_t_11),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_valid_res(rsp_valid_res), .rsp_metric(rsp_metric),
      .rsp_grad_00(rsp_grad_00), .rsp_grad_01(rsp_grad_01),
      .rsp_grad_10(rsp_grad_10), .rsp_grad_11(rsp_grad_11),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_min_det(csr_min_det)
   );

   // response side: sample at the edge, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_valid_res, rsp_metric, rsp_grad_00, rsp_grad_01,
                              rsp_grad_10, rsp_grad_11);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > STALL_MAX) begin
            $display("watchdog: no progress for %0d cycles", STALL_MAX);
            $display("status: fail");
            $finish;
         end
      end
   end

   // one request, held until accepted; optional idle gap first
   task automatic send_matrix(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              logic [15:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_t_00 <= a; req_t_01 <= b; req_t_10 <= c; req_t_11 <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(a, b, c, d);
      n_requests++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every response, then for the pipe to drain
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_min_det(logic [30:0] value);
      csr_valid <= 1'b1;
      csr_min_det <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.min_det = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // random entry, biased toward the extremes and small magnitudes
   function automatic logic [15:0] rand_entry();
      case ($urandom_range(5))
         0: return 16'h8000 + 16'($urandom_range(3));
         1: return 16'h7FFF - 16'($urandom_range(3));
         2: return 16'($signed(12'($urandom)));
         default: return 16'($urandom);
      endcase
   endfunction

   // random matrix; mostly of positive determinant so that the full maths runs
   task automatic random_matrix();
      logic [15:0] a, b, c, d;
      a = rand_entry(); b = rand_entry(); c = rand_entry(); d = rand_entry();
      if ($urandom_range(99) < 75 &&
          ($signed(a) * $signed(d) - $signed(b) * $signed(c)) <= 0)
         d = -d;
      if ($urandom_range(9) == 0) begin
         // near identity: metric and gradient close to zero
         a = 16'h1000 + 16'($urandom_range(15)); d = 16'h1000 - 16'($urandom_range(15));
         b = 16'($urandom_range(7)); c = 16'($urandom_range(7));
      end
      send_matrix(a, b, c, d);
   endtask

   task automatic run_phase(int n, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n) random_matrix();
      drop_valid();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, zero det, negative det, extremes, tiny det
      send_matrix(16'h1000, 16'h0000, 16'h0000, 16'h1000);
      send_matrix(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_matrix(16'h1000, 16'h1000, 16'h1000, 16'h1000);
      send_matrix(16'h0000, 16'h1000, 16'h1000, 16'h0000);
      send_matrix(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
      send_matrix(16'h8000, 16'h0000, 16'h0000, 16'h8000);
      send_matrix(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
      send_matrix(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
      send_matrix(16'h0001, 16'h0000, 16'h0000, 16'h0001);
      send_matrix(16'h0001, 16'h0001, 16'h0000, 16'h0001);
      send_matrix(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      send_matrix(16'h2000, 16'h0800, 16'hF800, 16'h0800);
      send_matrix(16'h0400, 16'h0000, 16'h0000, 16'h7FFF);
      send_matrix(16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
      send_matrix(16'h5555, 16'hAAAA, 16'h5555, 16'h5555);
      drop_valid();
      drain();

      // min_det of zero: zero determinant still rejected
      write_min_det(31'd0);
      send_matrix(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_matrix(16'h0001, 16'h0000, 16'h0000, 16'h0001);
      run_phase(150, 0, 0);
      drain();

      // large threshold, around 1.0 in q8.24
      write_min_det(31'h0100_0000);
      send_matrix(16'h1000, 16'h0000, 16'h0000, 16'h1000);
      send_matrix(16'h1000, 16'h0001, 16'h0000, 16'h0FFF);
      run_phase(200, 45, 0);
      drain();

      write_min_det(31'($urandom_range(1 << 20)));
      run_phase(200, 0, 45);
      drain();

      // maximum threshold rejects almost all
      write_min_det(31'h7FFF_FFFF);
      send_matrix(16'h8000, 16'h0000, 16'h0000, 16'h8000);
      run_phase(50, 33, 33);
      drain();

      write_min_det(31'd1);
      run_phase(250, 33, 33);
      drain();

      $display("covered %0d matrices over five min_det settings, %0d with accepted det",
               n_requests, sb.n_valid);
      $display("checked %0d responses, %0d mismatches", sb.n_checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/ssob_pkg.sv
rtl/ssob_front.sv
rtl/ssob_div.sv
rtl/shape_size_orient_barrier_2x2_core.sv
tb/tb.sv
